/* sv/temporal_median_pixel_filter_assert.svh */
// Assertion macros shared by the checker of the temporal median filter.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef TEMPORAL_MEDIAN_PIXEL_FILTER_ASSERT_SVH
`define TEMPORAL_MEDIAN_PIXEL_FILTER_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define TMPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("temporal median filter check failed");

// The consequence must hold in the cycle after the antecedent.
`define TMPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("temporal median filter check failed");

`endif

/* sv/tmpf_pkg.sv */
`default_nettype none

package tmpf_pkg;

    localparam int PIX_W  = 8;
    localparam int WIN    = 7;
    localparam int MID    = 3;
    localparam int RANK_W = 3;
    localparam int CFG_W  = 9;
    localparam int DIM_W  = 13;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN-1:0] win_vals_t;
    typedef logic [WIN-1:0][WIN-1:0] cmp_mat_t;

    typedef enum logic [1:0] {
        CFG_WINDOW_MODE  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    // Load enables of the two median stages, driven by the top-level flow control.
    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } pipe_en_t;

    // Index of the last pixel along one dimension: the raw value clamped to 1..maxv, less one.
    function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] raw, input int maxv);
        logic [DIM_W-1:0] ext;
        logic [DIM_W-1:0] lim;
        ext = {{(DIM_W-CFG_W){1'b0}}, raw};
        lim = DIM_W'(maxv);
        if (raw == '0)
            dim_last = '0;
        else if (ext > lim)
            dim_last = lim - DIM_W'(1);
        else
            dim_last = ext - DIM_W'(1);
    endfunction

endpackage

`default_nettype wire

/* sv/temporal_median_pixel_filter.sv */
`default_nettype none

// Temporal median filter for 8-bit grey video. Pixels arrive in raster order, one per
// transaction on the s_ side, and for each one a transaction on the m_ side carries the
// median of that pixel position over the current frame and the previous 2, 4 or 6 frames
// (window_mode 0, 1 or 2 on the configuration port; 3 acts as 2), with m_tlast marking the
// last pixel of a frame. One pixel is taken every clock cycle unless the m_ side stalls,
// and a result passes through the history read, comparison and rank stages; the rate is
// set by the history memory, read and written once per pixel through one read and one
// write port. Any register write, even of an unchanged value, restarts at the first
// pixel of a frame and forgets the history: during the first frame after it, the old
// memory contents are neither used nor needed, since every missing history slot stands
// for the current pixel. The memory is not cleared after reset and no clearing pass is
// needed. Configuration may only be written while no pixel is in flight.
module temporal_median_pixel_filter #(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int HISTORY_FRAMES = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Pixel input stream.
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,    // [7:0] pixel_value
    // Result stream.
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,    // [7:0] median_value
    output logic                            m_tlast,    // frame_end
    // Configuration write channel.
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [tmpf_pkg::CFG_W-1:0] cfg_data
);

    import tmpf_pkg::*;

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = CW + RW;
    localparam int HIST_W = PIX_W * HISTORY_FRAMES;
    localparam logic [2:0] PREV_LIMIT = 3'(HISTORY_FRAMES & ~1);
    localparam logic [2:0] HELD_MAX   = 3'(HISTORY_FRAMES);

    // Configuration registers.
    logic [1:0]       mode_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // Frame position and fill state.
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [2:0]    held_reg;

    // Pipeline stage registers.
    logic              v1_reg;
    pix_t              pix1_reg;
    logic [ADDR_W-1:0] addr1_reg;
    logic              first1_reg;
    logic              last1_reg;
    logic              v2_reg;
    logic              last2_reg;
    logic              mval_reg;
    logic              mlast_reg;

    logic [CW-1:0]     w_last;
    logic [RW-1:0]     h_last;
    logic              col_end;
    logic              row_end;
    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              in_acc;
    logic              hist_we;
    logic [ADDR_W-1:0] cur_addr;
    logic [HIST_W-1:0] hist_rd;
    logic [HIST_W-1:0] hist_wr;
    logic [1:0]        mode_sat;
    logic [2:0]        prev_raw;
    logic [2:0]        prev_cnt;
    pix_t [WIN-2:0]    slot_hist;
    win_vals_t         win_vals;
    pipe_en_t          pipe_en;
    pix_t              median;

    // Ready travels back through the stages: a stage may take a new item when it is
    // empty or when its current item moves on in the same cycle.
    assign rdy3     = !mval_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_acc   = s_tvalid && rdy1;

    assign cfg_ready = 1'b1;

    assign w_last   = CW'(dim_last(width_reg, MAX_WIDTH));
    assign h_last   = RW'(dim_last(height_reg, MAX_HEIGHT));
    assign col_end  = (col_reg == w_last);
    assign row_end  = (row_reg == h_last);
    assign cur_addr = {row_reg, col_reg};

    // Configuration and frame position. A configuration write restarts the frame and
    // empties the history; transactions to an index beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd0;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW_MODE:
                begin
                    mode_reg <= cfg_data[1:0];
                    col_reg  <= '0;
                    row_reg  <= '0;
                    held_reg <= '0;
                end
                CFG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_data;
                    col_reg   <= '0;
                    row_reg   <= '0;
                    held_reg  <= '0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_data;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    held_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_acc)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                if (row_end)
                begin
                    row_reg <= '0;
                    if (held_reg < HELD_MAX)
                        held_reg <= held_reg + 3'd1;
                end
                else
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            mval_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_acc;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                mval_reg <= v2_reg;
        end
    end

    // Stage one: pixel and its position while the history word is read; frame-end flags.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix1_reg   <= s_tdata;
            addr1_reg  <= cur_addr;
            first1_reg <= (held_reg == 3'd0);
            last1_reg  <= col_end && row_end;
        end
        if (pipe_en.s2_load)
            last2_reg <= last1_reg;
        if (pipe_en.s3_load)
            mlast_reg <= last2_reg;
    end

    // The history word is written back as the item leaves stage one. Only one item can
    // sit in stage one, so a following item at the same position sees the new word
    // through the read bypass of the memory.
    assign hist_we = v1_reg && rdy2;
    assign hist_wr = first1_reg ? {HISTORY_FRAMES{pix1_reg}}
                                : {hist_rd[HIST_W-PIX_W-1:0], pix1_reg};

    tmpf_history #(
        .ADDR_W (ADDR_W),
        .DATA_W (HIST_W)
    ) u_history (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (cur_addr),
        .wr_en   (hist_we),
        .wr_addr (addr1_reg),
        .wr_data (hist_wr),
        .rd_data (hist_rd)
    );

    // Number of previous frames in the window, limited by the depth of the history.
    assign mode_sat = (mode_reg > 2'd2) ? 2'd2 : mode_reg;
    assign prev_raw = {mode_sat, 1'b0} + 3'd2;
    assign prev_cnt = (prev_raw > PREV_LIMIT) ? PREV_LIMIT : prev_raw;

    for (genvar k = 0; k < WIN - 1; k++)
    begin : g_slot
        if (k < HISTORY_FRAMES)
        begin : g_held
            assign slot_hist[k] = hist_rd[k*PIX_W +: PIX_W];
        end
        else
        begin : g_none
            assign slot_hist[k] = '0;
        end
    end

    // The median is always taken over seven slots. Slots outside the window are filled in
    // pairs of the smallest and largest code, which leaves the median unchanged.
    always_comb
    begin
        win_vals[0] = pix1_reg;
        for (int i = 1; i < WIN; i++)
        begin
            if (3'(i) <= prev_cnt)
                win_vals[i] = first1_reg ? pix1_reg : slot_hist[i-1];
            else if ((i % 2) == 1)
                win_vals[i] = '0;
            else
                win_vals[i] = '1;
        end
    end

    assign pipe_en.s2_load = v1_reg && rdy2;
    assign pipe_en.s3_load = v2_reg && rdy3;

    tmpf_median7 u_median (
        .clk    (clk),
        .en     (pipe_en),
        .vals   (win_vals),
        .median (median)
    );

    assign m_tvalid = mval_reg;
    assign m_tdata  = median;
    assign m_tlast  = mlast_reg;

endmodule

`default_nettype wire

/* sv/tmpf_history.sv */
`default_nettype none

module tmpf_history #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 48
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic      [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // A read that meets a write to the same entry returns the new word.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/tmpf_median7.sv */
`default_nettype none

module tmpf_median7 (
    input  wire logic                clk,
    input  wire tmpf_pkg::pipe_en_t  en,
    input  wire tmpf_pkg::win_vals_t vals,
    output tmpf_pkg::pix_t           median
);

    import tmpf_pkg::*;

    cmp_mat_t                    cmp_next;
    cmp_mat_t                    cmp_reg;
    win_vals_t                   vals_reg;
    logic [WIN-1:0][RANK_W-1:0] rank;
    pix_t                        median_next;
    pix_t                        median_reg;

    // Stage two: all pairwise comparisons. Ties are broken by slot so ranks are distinct.
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if (j == i)
                    cmp_next[i][j] = 1'b0;
                else if (j < i)
                    cmp_next[i][j] = (vals[j] <= vals[i]);
                else
                    cmp_next[i][j] = (vals[j] < vals[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2_load)
        begin
            cmp_reg  <= cmp_next;
            vals_reg <= vals;
        end
    end

    // Stage three: rank of each slot, then pick the slot whose rank is the middle one.
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < WIN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WIN; j++)
                rank[i] = rank[i] + RANK_W'(cmp_reg[i][j]);
            if (rank[i] == RANK_W'(MID))
                median_next = median_next | vals_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3_load)
            median_reg <= median_next;
    end

    assign median = median_reg;

endmodule

`default_nettype wire

/* sv/tmpf_checker.sv */
`default_nettype none

`include "temporal_median_pixel_filter_assert.svh"

module tmpf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    logic [2:0] inflight_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Pixels taken whose results have not yet been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else if (in_acc && !out_acc)
            inflight_reg <= inflight_reg + 3'd1;
        else if (out_acc && !in_acc)
            inflight_reg <= inflight_reg - 3'd1;
    end

    `TMPF_ASSERT_IMP(a_inflight_bound, 1'b1, inflight_reg <= 3'd3)
    `TMPF_ASSERT_IMP(a_no_spurious_result, m_tvalid, inflight_reg != 3'd0)
    `TMPF_ASSERT_IMP(a_ready_when_drained, !m_tvalid, s_tready)
    `TMPF_ASSERT_NXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind temporal_median_pixel_filter tmpf_checker u_tmpf_checker (.*);

`default_nettype wire

/* bench/tmpf_median_checker.sv */
// Watches the pixel, result and configuration channels of the temporal median
// filter, keeps its own copy of the per-position history and compares every
// result transaction against the oldest predicted median.
module tmpf_median_checker #(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int HISTORY_FRAMES = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,
    input  logic                       m_tlast,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [tmpf_pkg::CFG_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending
);
    import tmpf_pkg::*;

    localparam int POSITIONS    = MAX_WIDTH * MAX_HEIGHT;
    localparam int EVEN_HISTORY = HISTORY_FRAMES & ~1;

    typedef struct {
        pix_t median;
        logic frame_end;
    } median_result_t;

    pix_t           pixel_history [POSITIONS][HISTORY_FRAMES];
    logic [1:0]     window_sel;
    logic [CFG_W-1:0] width_raw;
    logic [CFG_W-1:0] height_raw;
    int unsigned    frames_seen;
    int unsigned    raster_pos;
    int unsigned    results_seen;
    median_result_t median_q[$];

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                              input int unsigned maxv);
        if (raw == '0)
            return 1;
        if (raw > maxv)
            return maxv;
        return raw;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        case (idx)
            CFG_WINDOW_MODE:  window_sel = value[1:0];
            CFG_FRAME_WIDTH:  width_raw  = value;
            CFG_FRAME_HEIGHT: height_raw = value;
            default:          return;
        endcase
        // Any accepted register write forgets the history.
        frames_seen = 0;
        raster_pos  = 0;
    endtask

    task automatic predict_median(input pix_t px);
        pix_t           sorted [HISTORY_FRAMES+1];
        pix_t           held;
        median_result_t want;
        int unsigned    total;
        int unsigned    span;
        int unsigned    prev;
        int unsigned    count;
        int unsigned    pos;
        int unsigned    i;
        int unsigned    j;

        total = clamp_dim(width_raw, MAX_WIDTH) * clamp_dim(height_raw, MAX_HEIGHT);
        span  = (window_sel > 2'd2) ? 2 : window_sel;
        prev  = 2 * (span + 1);
        if (prev > EVEN_HISTORY)
            prev = EVEN_HISTORY;
        if (raster_pos >= total)
            raster_pos = 0;
        pos = raster_pos;

        sorted[0] = px;
        for (i = 0; i < prev; i++)
            sorted[i+1] = (frames_seen == 0) ? px : pixel_history[pos][i];
        count = prev + 1;

        for (i = 1; i < count; i++)
        begin
            held = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > held)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = held;
        end

        if (frames_seen == 0)
        begin
            for (i = 0; i < HISTORY_FRAMES; i++)
                pixel_history[pos][i] = px;
        end
        else
        begin
            for (i = HISTORY_FRAMES - 1; i > 0; i--)
                pixel_history[pos][i] = pixel_history[pos][i-1];
            pixel_history[pos][0] = px;
        end

        want.median    = sorted[count/2];
        want.frame_end = (pos == total - 1);
        if (want.frame_end)
        begin
            raster_pos = 0;
            if (frames_seen < HISTORY_FRAMES)
                frames_seen++;
        end
        else
            raster_pos = pos + 1;
        median_q = {median_q, want};
    endtask

    task automatic check_result();
        median_result_t want;
        if (median_q.size() == 0)
        begin
            report_mismatch($sformatf("median %0d last %0b with no pixel outstanding",
                                      m_tdata, m_tlast));
            results_seen++;
            return;
        end
        want = median_q.pop_front();
        if (m_tdata !== want.median)
            report_mismatch($sformatf("median %0d, predicted %0d", m_tdata, want.median));
        if (m_tlast !== want.frame_end)
            report_mismatch($sformatf("frame end %0b, predicted %0b", m_tlast, want.frame_end));
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sel   = '0;
            width_raw    = CFG_W'(256);
            height_raw   = CFG_W'(256);
            frames_seen  = 0;
            raster_pos   = 0;
            results_seen = 0;
            errors       = 0;
            median_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                predict_median(s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = median_q.size();
    end

endmodule

/* bench/temporal_median_pixel_filter_tb.sv */
// Top of the temporal median filter bench. This module only makes stimulus and
// gives the verdict; all prediction and comparison lives in the checker beside
// the block.
module temporal_median_pixel_filter_tb;
    import tmpf_pkg::*;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int HISTORY_FRAMES = 6;

    // Settling time after the last result, before touching the configuration or
    // ending the run.
    localparam int PIPE_SETTLE   = 8;
    localparam int TARGET_PIXELS = 1850;
    localparam int TAIL_PIXELS   = 1600;

    // Index 3 lies beyond the register list and must be ignored by the block.
    localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int errors;
    int pending;
    int pixels_sent;
    int send_gap_pct;
    int recv_stall_pct;
    int stall_left;
    bit tail;

    temporal_median_pixel_filter #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .HISTORY_FRAMES (HISTORY_FRAMES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tmpf_median_checker #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .HISTORY_FRAMES (HISTORY_FRAMES)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard limit on the run. The slowest legal run, with every transaction
    // meeting the longest gap and the longest stall, stays below a fifth of
    // this.
    initial
    begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: the receiver drops tready in bursts at random. The
    // burst rate is varied by the stimulus from phase to phase, and in the
    // tail of the run the receiver is always ready.
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!tail && rst_n && $urandom_range(99) < recv_stall_pct)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(11);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Holds the pixel channel idle for a number of cycles, with junk on the
    // data lines so that nothing is taken while tvalid is low.
    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
        end
    endtask

    // Offers one pixel and waits for its transaction. tvalid stays high on
    // return, so back-to-back pixels go out on consecutive cycles.
    task automatic send_pixel(input pix_t px);
        if (!tail && $urandom_range(99) < send_gap_pct)
            pause_sender($urandom_range(1, 12));
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        if (pixels_sent >= TAIL_PIXELS)
            tail = 1'b1;
    endtask

    // Stops the sender and waits until every predicted median has been
    // delivered, then lets the pipeline settle.
    task automatic wait_drained();
        pause_sender(1);
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= CFG_W'($urandom);
    endtask

    task automatic configure(input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] width,
                             input logic [CFG_W-1:0] height);
        wait_drained();
        write_reg(CFG_WINDOW_MODE, mode);
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
    endtask

    // Streams a run of pixels over frames of the given size. Style 0 is plain
    // noise; style 1 is a steady scene per position with small jitter and the
    // odd outlier, which is where a median earns its keep; style 2 uses only
    // black and white. With hold_mid set, the sender stops halfway and waits
    // until the block has caught up completely.
    task automatic stream_frames(input int unsigned count, input int unsigned frame_pixels,
                                 input int unsigned style, input bit hold_mid);
        pix_t        scene [64];
        int          v;
        int unsigned n;
        int unsigned k;

        for (k = 0; k < 64; k++)
            scene[k] = 8'($urandom);
        for (n = 0; n < count; n++)
        begin
            if (hold_mid && n == count / 2)
                wait_drained();
            k = (n % frame_pixels) % 64;
            case (style)
                0:
                    v = int'($urandom_range(255));
                1:
                begin
                    if ($urandom_range(9) == 0)
                        v = int'($urandom_range(255));
                    else
                        v = int'(scene[k]) + int'($urandom_range(6)) - 3;
                end
                default:
                    v = $urandom_range(1) ? 255 : 0;
            endcase
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            send_pixel(pix_t'(v));
        end
    endtask

    function automatic int pick_rate();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned count;

        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_WINDOW_MODE;
        cfg_data       = '0;
        rst_n          = 1'b0;
        tail           = 1'b0;
        pixels_sent    = 0;
        send_gap_pct   = 20;
        recv_stall_pct = 20;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Out of reset the frame is 256 by 256 and no history exists yet, so
        // each pixel comes back unchanged.
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);

        // Window mode three behaves as the seven-frame window, and zero sizes
        // mean one pixel per frame, so every result closes a frame and the
        // history fills up and then saturates.
        configure(CFG_W'(3), CFG_W'(0), CFG_W'(0));
        send_pixel(8'd10);
        send_pixel(8'd200);
        send_pixel(8'd30);
        send_pixel(8'd250);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd7);

        // A write to the spare index must leave the history in place.
        wait_drained();
        write_reg(CFG_INDEX_SPARE, '1);
        send_pixel(8'd90);
        send_pixel(8'd91);

        // Only the low two bits of the window write select the mode.
        configure(CFG_W'(9'h1FD), CFG_W'(1), CFG_W'(1));
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd100);

        // Largest line, then the tallest frame with an oversized height that
        // saturates; the second one also stalls the sender until the block is
        // empty in the middle of a frame.
        configure(CFG_W'(1), CFG_W'(256), CFG_W'(1));
        stream_frames(264, 256, 1, 1'b0);
        configure(CFG_W'(2), CFG_W'(1), CFG_W'(511));
        stream_frames(264, 256, 1, 1'b1);

        // Random phases over small frames, so that the history goes through
        // filling and saturation many times with every window size.
        while (pixels_sent < TARGET_PIXELS)
        begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            wait_drained();
            if ($urandom_range(3) != 0)
                write_reg(CFG_WINDOW_MODE,
                          {(CFG_W-2)'($urandom_range(127)), 2'($urandom_range(3))});
            write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
            send_gap_pct   = pick_rate();
            recv_stall_pct = pick_rate();
            frames = $urandom_range(3, 12);
            count  = frames * w * h;
            if ($urandom_range(1) != 0)
                count += $urandom_range(w * h - 1);
            stream_frames(count, w * h, $urandom_range(2), $urandom_range(3) == 0);
        end

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/tmpf_pkg.sv
sv/tmpf_history.sv
sv/tmpf_median7.sv
sv/temporal_median_pixel_filter.sv
sv/tmpf_checker.sv
bench/tmpf_median_checker.sv
bench/temporal_median_pixel_filter_tb.sv
